// File: hw/rtl/audio_level_peak_meter_unit_assert.svh
// Assertion macros for the audio level peak meter RTL.
// Uses the clk and arst_n names of the module that includes it.
`ifndef AUDIO_LEVEL_PEAK_METER_UNIT_ASSERT_SVH
`define AUDIO_LEVEL_PEAK_METER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define ALMP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define ALMP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ALMP_ASSERT_SAME(lbl, ante, cons, msg)
`define ALMP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/almp_pkg.sv
// Package of the audio level peak meter: widths, register indexes, codes and
// the command, status and configuration structs. No dependencies.
package almp_pkg;

	localparam int TRACKS     = 8;
	localparam int CH_W       = 3;
	localparam int SMP_W      = 24;
	localparam int BUF_W      = 16;
	localparam int LVL_W      = 32;
	localparam int COEF_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int STEP_W     = 5;
	localparam int Q_SHIFT    = 31;
	// signed coefficient times zero-extended level
	localparam int PROD_W     = COEF_W + LVL_W + 1;
	localparam int TERM_W     = PROD_W - Q_SHIFT;
	localparam int ACC_W      = TERM_W + 1;

	localparam logic [STEP_W-1:0] LAST_STEP      = STEP_W'(16);
	localparam logic [BUF_W-1:0]  INTERVAL_RESET = BUF_W'(6000);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RISE_A0    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_RISE_B1    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_FAST_DC_A0 = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_FAST_DC_B1 = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_DC_A0 = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_DC_B1 = CFG_IDX_W'(6);

	// filter evaluation order within one item
	typedef enum logic [1:0] {
		FLT_FAST_RISE  = 2'd0,
		FLT_FAST_DECAY = 2'd1,
		FLT_PEAK_RISE  = 2'd2,
		FLT_PEAK_DECAY = 2'd3
	} filt_t;

	// phase within one filter evaluation
	typedef enum logic [1:0] {
		PH_X   = 2'd0, // a0 * x
		PH_LX  = 2'd1, // a0 * x_prev, acc loads a0 * x
		PH_FB  = 2'd2, // b1 * y, acc adds a0 * x_prev
		PH_SUB = 2'd3  // acc subtracts b1 * y
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOAD  = 4'b0010,
		ST_MAC   = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

	typedef struct packed {
		logic [BUF_W-1:0]  interval_samples;
		logic [COEF_W-1:0] rise_a0;
		logic [COEF_W-1:0] rise_b1;
		logic [COEF_W-1:0] fast_decay_a0;
		logic [COEF_W-1:0] fast_decay_b1;
		logic [COEF_W-1:0] peak_decay_a0;
		logic [COEF_W-1:0] peak_decay_b1;
	} cfg_t;

	typedef struct packed {
		logic   accept;
		logic   load;
		logic   book;
		logic   mac;
		phase_t phase;
		filt_t  filt;
		logic   commit;
		filt_t  commit_filt;
		logic   write;
	} ctl_t;

	typedef struct packed {
		logic stall;
	} sts_t;

endpackage

// File: hw/rtl/almp_in_if.sv
// Input channel interface: one track sample and its buffer size.
// Depends on almp_pkg.
interface almp_in_if;
	logic                             valid;
	logic                             ready;
	logic [almp_pkg::CH_W-1:0]        channel;
	logic signed [almp_pkg::SMP_W-1:0] sample;
	logic [almp_pkg::BUF_W-1:0]       buffer_size;

	modport source (output valid, channel, sample, buffer_size, input ready);
	modport sink (input valid, channel, sample, buffer_size, output ready);
endinterface

// File: hw/rtl/almp_out_if.sv
// Output channel interface: one track level report.
// Depends on almp_pkg.
interface almp_out_if;
	logic                       valid;
	logic                       ready;
	logic [almp_pkg::CH_W-1:0]  channel_res;
	logic [almp_pkg::LVL_W-1:0] fast_level;
	logic [almp_pkg::LVL_W-1:0] peak_level;

	modport source (output valid, channel_res, fast_level, peak_level, input ready);
	modport sink (input valid, channel_res, fast_level, peak_level, output ready);
endinterface

// File: hw/rtl/almp_cfg.sv
// Configuration register bank of the level meter.
// Depends on almp_pkg.
module almp_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic [almp_pkg::CFG_IDX_W-1:0]      idx,
	input  logic [almp_pkg::CFG_DATA_W-1:0]     data,
	output almp_pkg::cfg_t                      cfg
);

	almp_pkg::cfg_t cfg_q;

	// register writes; unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval_samples <= almp_pkg::INTERVAL_RESET;
			cfg_q.rise_a0          <= '0;
			cfg_q.rise_b1          <= '0;
			cfg_q.fast_decay_a0    <= '0;
			cfg_q.fast_decay_b1    <= '0;
			cfg_q.peak_decay_a0    <= '0;
			cfg_q.peak_decay_b1    <= '0;
		end else if (we) begin
			unique case (idx)
				almp_pkg::REG_INTERVAL:   cfg_q.interval_samples <= data[almp_pkg::BUF_W-1:0];
				almp_pkg::REG_RISE_A0:    cfg_q.rise_a0          <= data;
				almp_pkg::REG_RISE_B1:    cfg_q.rise_b1          <= data;
				almp_pkg::REG_FAST_DC_A0: cfg_q.fast_decay_a0    <= data;
				almp_pkg::REG_FAST_DC_B1: cfg_q.fast_decay_b1    <= data;
				almp_pkg::REG_PEAK_DC_A0: cfg_q.peak_decay_a0    <= data;
				almp_pkg::REG_PEAK_DC_B1: cfg_q.peak_decay_b1    <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/almp_ctrl.sv
// Sequencer of the level meter: accept, load track state, run the shared
// multiply-accumulate schedule, write back. Depends on almp_pkg and the
// assertion macro header.
`include "audio_level_peak_meter_unit_assert.svh"

module almp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  almp_pkg::sts_t sts,
	output almp_pkg::ctl_t cmd
);

	almp_pkg::state_t                state_q, state_d;
	logic [almp_pkg::STEP_W-1:0]     step_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			almp_pkg::ST_IDLE:  if (in_valid) state_d = almp_pkg::ST_LOAD;
			almp_pkg::ST_LOAD:  state_d = almp_pkg::ST_MAC;
			almp_pkg::ST_MAC:   if (step_q == almp_pkg::LAST_STEP) state_d = almp_pkg::ST_WRITE;
			almp_pkg::ST_WRITE: if (!sts.stall) state_d = almp_pkg::ST_IDLE;
			default:            state_d = almp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= almp_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == almp_pkg::ST_LOAD) begin
				step_q <= '0;
			end else if (state_q == almp_pkg::ST_MAC && step_q != almp_pkg::LAST_STEP) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// commands: four filters of four steps, commit overlaps the next filter
	always_comb begin
		cmd             = '0;
		cmd.accept      = (state_q == almp_pkg::ST_IDLE) && in_valid;
		cmd.load        = (state_q == almp_pkg::ST_LOAD);
		cmd.book        = (state_q == almp_pkg::ST_MAC) && (step_q == '0);
		cmd.mac         = (state_q == almp_pkg::ST_MAC) && !step_q[almp_pkg::STEP_W-1];
		cmd.phase       = almp_pkg::phase_t'(step_q[1:0]);
		cmd.filt        = almp_pkg::filt_t'(step_q[3:2]);
		cmd.commit      = (state_q == almp_pkg::ST_MAC) && (step_q[1:0] == 2'd0)
			&& (step_q != '0);
		cmd.commit_filt = almp_pkg::filt_t'(step_q[3:2] - 2'd1);
		cmd.write       = (state_q == almp_pkg::ST_WRITE) && !sts.stall;
	end

	assign in_ready = (state_q == almp_pkg::ST_IDLE);

	`ALMP_ASSERT_NEXT(a_accept_load, state_q == almp_pkg::ST_IDLE && in_valid, state_q == almp_pkg::ST_LOAD, "accepted item did not start loading")
	`ALMP_ASSERT_NEXT(a_load_mac, state_q == almp_pkg::ST_LOAD, state_q == almp_pkg::ST_MAC && step_q == '0, "schedule did not start at step zero")
	`ALMP_ASSERT_NEXT(a_mac_steps, state_q == almp_pkg::ST_MAC && step_q != almp_pkg::LAST_STEP, state_q == almp_pkg::ST_MAC && step_q == $past(step_q) + 1'b1, "schedule left or skipped a step")
	`ALMP_ASSERT_SAME(a_write_hold, state_q == almp_pkg::ST_WRITE && sts.stall, !cmd.write && !in_ready, "write-back while output is blocked")

endmodule

// File: hw/rtl/almp_dp.sv
// Datapath of the level meter: per-track state, shared 32x33 multiplier with
// accumulator and saturation, report bookkeeping and the output register.
// Depends on almp_pkg.
module almp_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  almp_pkg::ctl_t                     cmd,
	output almp_pkg::sts_t                     sts,
	input  almp_pkg::cfg_t                     cfg,
	input  logic [almp_pkg::CH_W-1:0]          channel,
	input  logic signed [almp_pkg::SMP_W-1:0]  sample,
	input  logic [almp_pkg::BUF_W-1:0]         buffer_size,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [almp_pkg::CH_W-1:0]          channel_res,
	output logic [almp_pkg::LVL_W-1:0]         fast_level,
	output logic [almp_pkg::LVL_W-1:0]         peak_level
);

	localparam int LVL_W  = almp_pkg::LVL_W;
	localparam int SMP_W  = almp_pkg::SMP_W;
	localparam int BUF_W  = almp_pkg::BUF_W;
	localparam int PROD_W = almp_pkg::PROD_W;
	localparam int TERM_W = almp_pkg::TERM_W;
	localparam int ACC_W  = almp_pkg::ACC_W;
	localparam int PAD_W  = LVL_W - SMP_W;

	// per-track state
	logic [LVL_W-1:0] fast_mem_q [almp_pkg::TRACKS];
	logic [LVL_W-1:0] peak_mem_q [almp_pkg::TRACKS];
	logic [SMP_W-1:0] prev_mem_q [almp_pkg::TRACKS];
	logic [BUF_W-1:0] pos_mem_q  [almp_pkg::TRACKS];
	logic [BUF_W-1:0] mark_mem_q [almp_pkg::TRACKS];

	// item registers
	logic [almp_pkg::CH_W-1:0] ch_q;
	logic [SMP_W-1:0]          mag_q;
	logic [BUF_W-1:0]          samples_q;
	logic [BUF_W-1:0]          t_q;
	logic [BUF_W-1:0]          mark_q;
	logic [LVL_W-1:0]          yf_q, yp_q, lx_q;
	logic                      last_q, report_q;
	logic [BUF_W-1:0]          mark_nx_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;

	// output register
	logic                      res_valid_q;
	logic [almp_pkg::CH_W-1:0] res_ch_q;
	logic [LVL_W-1:0]          res_fast_q, res_peak_q;

	logic [SMP_W-1:0]         sample_u, mag;
	logic [LVL_W-1:0]         x;
	logic [BUF_W-1:0]         spu;
	logic [almp_pkg::COEF_W-1:0] a0, b1;
	logic signed [almp_pkg::COEF_W-1:0] coef;
	logic [LVL_W-1:0]         opnd;
	logic signed [PROD_W-1:0] prod;
	logic signed [TERM_W-1:0] term_raw;
	logic signed [ACC_W-1:0]  term;
	logic [LVL_W-1:0]         sat;
	logic [BUF_W:0]           mark_p1;
	logic [BUF_W+1:0]         mark_p2;
	logic                     last_c, report_c;

	// rectify to Q1.23 magnitude; full scale negative stays 2^23
	assign sample_u = sample;
	assign mag      = sample_u[SMP_W-1] ? (~sample_u + 1'b1) : sample_u;
	assign x        = {mag_q, {PAD_W{1'b0}}};
	assign spu      = (cfg.interval_samples == '0) ? BUF_W'(1) : cfg.interval_samples;

	// latch the transaction
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ch_q      <= channel;
			mag_q     <= mag;
			samples_q <= (buffer_size == '0) ? BUF_W'(1) : buffer_size;
		end
	end

	// load track state, buffer start takes the fast level as x_prev
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q <= pos_mem_q[ch_q];
			if (pos_mem_q[ch_q] == '0) begin
				mark_q <= spu;
				lx_q   <= fast_mem_q[ch_q];
			end else begin
				mark_q <= mark_mem_q[ch_q];
				lx_q   <= {prev_mem_q[ch_q], {PAD_W{1'b0}}};
			end
		end
	end

	// report bookkeeping
	assign mark_p1  = {1'b0, mark_q} + {1'b0, spu};
	assign mark_p2  = {2'b00, mark_q} + {1'b0, spu, 1'b0};
	assign last_c   = (t_q >= samples_q - 1'b1);
	assign report_c = (t_q > mark_q) || last_c;

	always_ff @(posedge clk) begin
		if (cmd.book) begin
			last_q   <= last_c;
			report_q <= report_c;
			if (!report_c) begin
				mark_nx_q <= mark_q;
			end else if (mark_p2 > {2'b00, samples_q}) begin
				mark_nx_q <= samples_q - 1'b1;
			end else begin
				mark_nx_q <= mark_p1[BUF_W-1:0];
			end
		end
	end

	// coefficient and operand selection
	always_comb begin
		unique case (cmd.filt)
			almp_pkg::FLT_FAST_RISE, almp_pkg::FLT_PEAK_RISE: begin
				a0 = cfg.rise_a0;
				b1 = cfg.rise_b1;
			end
			almp_pkg::FLT_FAST_DECAY: begin
				a0 = cfg.fast_decay_a0;
				b1 = cfg.fast_decay_b1;
			end
			almp_pkg::FLT_PEAK_DECAY: begin
				a0 = cfg.peak_decay_a0;
				b1 = cfg.peak_decay_b1;
			end
			default: begin
				a0 = cfg.rise_a0;
				b1 = cfg.rise_b1;
			end
		endcase
		coef = (cmd.phase == almp_pkg::PH_FB) ? b1 : a0;
		unique case (cmd.phase)
			almp_pkg::PH_X:  opnd = x;
			almp_pkg::PH_LX: opnd = lx_q;
			default: begin
				if (cmd.filt == almp_pkg::FLT_PEAK_RISE || cmd.filt == almp_pkg::FLT_PEAK_DECAY) begin
					opnd = yp_q;
				end else begin
					opnd = yf_q;
				end
			end
		endcase
	end

	// shared multiplier, registered; floor to Q1.31 is an arithmetic shift
	assign prod     = coef * $signed({1'b0, opnd});
	assign term_raw = prod_q[PROD_W-1:almp_pkg::Q_SHIFT];
	assign term     = ACC_W'(term_raw);

	always_ff @(posedge clk) begin
		if (cmd.mac) begin
			prod_q <= prod;
			unique case (cmd.phase)
				almp_pkg::PH_X:   ;
				almp_pkg::PH_LX:  acc_q <= {term_raw[TERM_W-1], term_raw};
				almp_pkg::PH_FB:  acc_q <= acc_q + term;
				almp_pkg::PH_SUB: acc_q <= acc_q - term;
				default: ;
			endcase
		end
	end

	// saturate to [0, 2^32 - 1]
	always_comb begin
		if (acc_q[ACC_W-1]) begin
			sat = '0;
		end else if (|acc_q[ACC_W-2:LVL_W]) begin
			sat = '1;
		end else begin
			sat = acc_q[LVL_W-1:0];
		end
	end

	// level registers: load, then rise and decay commits
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			yf_q <= fast_mem_q[ch_q];
			yp_q <= peak_mem_q[ch_q];
		end else if (cmd.commit) begin
			unique case (cmd.commit_filt)
				almp_pkg::FLT_FAST_RISE:  if (x > yf_q) yf_q <= sat;
				almp_pkg::FLT_FAST_DECAY: yf_q <= sat;
				almp_pkg::FLT_PEAK_RISE:  if (x > yp_q) yp_q <= sat;
				almp_pkg::FLT_PEAK_DECAY: yp_q <= sat;
				default: ;
			endcase
		end
	end

	// write back track state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < almp_pkg::TRACKS; i++) begin
				fast_mem_q[i] <= '0;
				peak_mem_q[i] <= '0;
				prev_mem_q[i] <= '0;
				pos_mem_q[i]  <= '0;
				mark_mem_q[i] <= '0;
			end
		end else if (cmd.write) begin
			fast_mem_q[ch_q] <= yf_q;
			peak_mem_q[ch_q] <= yp_q;
			prev_mem_q[ch_q] <= mag_q;
			mark_mem_q[ch_q] <= mark_nx_q;
			pos_mem_q[ch_q]  <= last_q ? '0 : (t_q + 1'b1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.write && report_q) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write && report_q) begin
			res_ch_q   <= ch_q;
			res_fast_q <= yf_q;
			res_peak_q <= yp_q;
		end
	end

	assign sts.stall   = report_q && res_valid_q && !out_ready;
	assign out_valid   = res_valid_q;
	assign channel_res = res_ch_q;
	assign fast_level  = res_fast_q;
	assign peak_level  = res_peak_q;

endmodule

// File: hw/rtl/audio_level_peak_meter_unit.sv
// Multi-track audio level meter: one sample in, fast and peak level report
// out once per interval. An item is taken only while the sequencer is idle:
// a load of the track's state, the twelve filter products that go one at a
// time through the single 32x33 multiplier and its accumulator (each
// filter's feedback product needs the level the previous filter left), and
// a write of the state back; a report still waiting at the output delays
// that write-back only when the new item also reports. The level register
// takes the next item while a finished report waits. No clearing pass after
// reset: all track state is cleared at once. Depends on almp_pkg, the
// channel interfaces, almp_cfg, almp_ctrl and almp_dp.
module audio_level_peak_meter_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [almp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [almp_pkg::CFG_DATA_W-1:0] cfg_data,
	almp_in_if.sink                         in_ch,
	almp_out_if.source                      out_ch
);

	almp_pkg::cfg_t cfg;
	almp_pkg::ctl_t cmd;
	almp_pkg::sts_t sts;

	// register bank
	almp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_idx),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// sequencer
	almp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	almp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg         (cfg),
		.channel     (in_ch.channel),
		.sample      (in_ch.sample),
		.buffer_size (in_ch.buffer_size),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.channel_res (out_ch.channel_res),
		.fast_level  (out_ch.fast_level),
		.peak_level  (out_ch.peak_level)
	);

endmodule
